/* hw/rtl/assert_macros.svh */
// Assertion helper macros used by the median core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled in reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked on clk and disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/swm_pkg.sv */
// Shared types and constants of the running median filter.
package swm_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_W  = 33;
  localparam int WS_W   = 7;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EVICT,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  sample;
    logic signed [DATA_W-1:0]  evict_val;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EV_SEL,
    ST_EV_SHIFT,
    ST_INSERT,
    ST_PICK,
    ST_EMIT
  } swm_state_t;

endpackage

/* hw/rtl/swm_cell.sv */
// One slot of the sorted window: value, age and its shift/insert decision.
module swm_cell import swm_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [CNT_W-1:0]         fill,
  input  logic [IDX_W-1:0]         age_tgt,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic [IDX_W-1:0]         left_age,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] right_val,
  input  logic [IDX_W-1:0]         right_age,
  output logic signed [DATA_W-1:0] val,
  output logic [IDX_W-1:0]         age,
  output logic                     gt,
  output logic                     match
);

  localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]         age_r, age_nxt;
  logic                     valid;
  logic                     ge_ev;

  assign valid = POS < fill;
  // An empty slot counts as greater, so the new item lands at the end.
  assign gt    = !valid || (val_r > ctl.sample);
  assign ge_ev = valid && (val_r >= ctl.evict_val);
  assign match = valid && (age_r == age_tgt);
  assign val   = val_r;
  assign age   = age_r;

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r;
    case (ctl.op)
      CELL_EVICT: begin
        // close the gap left by the oldest entry
        if (ge_ev) begin
          val_nxt = right_val;
          age_nxt = right_age;
        end
      end
      CELL_INSERT: begin
        if (!gt) begin
          age_nxt = age_r + 1'b1;
        end else if (left_gt) begin
          val_nxt = left_val;
          age_nxt = left_age + 1'b1;
        end else begin
          val_nxt = ctl.sample;
          age_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

endmodule

/* hw/rtl/swm_chain.sv */
// Row of window cells with neighbor links and the value taps.
module swm_chain import swm_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [CNT_W-1:0]         fill,
  input  logic [IDX_W-1:0]         age_tgt,
  input  logic [IDX_W-1:0]         lo_idx,
  input  logic [IDX_W-1:0]         hi_idx,
  output logic signed [DATA_W-1:0] sel_val,
  output logic signed [DATA_W-1:0] lo_val,
  output logic signed [DATA_W-1:0] hi_val
);

  logic signed [DATA_W-1:0] cval  [MAX_WINDOW];
  logic [IDX_W-1:0]         cage  [MAX_WINDOW];
  logic                     cgt   [MAX_WINDOW];
  logic                     cmatch[MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [DATA_W-1:0] lv, rv;
    logic [IDX_W-1:0]         la, ra;
    logic                     lg;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign la = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cval[i-1];
      assign la = cage[i-1];
      assign lg = cgt[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rv = '0;
      assign ra = '0;
    end else begin : g_inner
      assign rv = cval[i+1];
      assign ra = cage[i+1];
    end

    swm_cell #(
      .IDX_W(IDX_W),
      .CNT_W(CNT_W),
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .fill     (fill),
      .age_tgt  (age_tgt),
      .left_val (lv),
      .left_age (la),
      .left_gt  (lg),
      .right_val(rv),
      .right_age(ra),
      .val      (cval[i]),
      .age      (cage[i]),
      .gt       (cgt[i]),
      .match    (cmatch[i])
    );
  end

  // AND-OR taps: at most one cell hits each of them
  always_comb begin
    sel_val = '0;
    lo_val  = '0;
    hi_val  = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (cmatch[i])
        sel_val = sel_val | cval[i];
      if (lo_idx == IDX_W'(i))
        lo_val = lo_val | cval[i];
      if (hi_idx == IDX_W'(i))
        hi_val = hi_val | cval[i];
    end
  end

endmodule

/* hw/rtl/sliding_window_median_core.sv */
// Running median filter: sorted chain of cells, twice the median per item.
//
// Input channel (in_*): one item per handshake, in_tdata = sample (signed 32),
// in_tuser = restart, which empties the window before the sample is taken.
// Result channel (out_*): out_tdata[32:0] = sum of the two middle sorted
// entries (twice the median); one item per input once the window is full,
// none while it fills. Configuration (cfg_*): window size, 1..MAX_WINDOW,
// 0 acts as 1 and larger values saturate; the user writes it only while the block
// is idle, and the block does not enforce this. An item short of a full window is
// accepted, checked and inserted; the item that fills it also has the middle taps
// picked and the sum registered; once full, the oldest entry is first selected and
// removed. Each extra entry leaving after the window size is lowered adds a check,
// select and remove. Cells update once per step, so one item is in work at a time.
// Reset empties the window and sets the window size to 1.
// If the receiver stalls, the result waits in the output register; the next
// input item is still taken and worked on up to its own result.
module sliding_window_median_core import swm_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [32:0] median_doubled, [39:33] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // [6:0] window_size
);

  `include "assert_macros.svh"

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

  swm_state_t state_r, state_nxt;

  logic [WS_W-1:0]          ws_r, ws_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic signed [DATA_W-1:0] sample_r, sample_nxt;
  logic signed [DATA_W-1:0] ev_r, ev_nxt;
  logic signed [DATA_W-1:0] lo_r, lo_nxt;
  logic signed [DATA_W-1:0] hi_r, hi_nxt;
  logic signed [OUT_W-1:0]  res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [CMP_W-1:0]         ws_ext;
  logic [CNT_W-1:0]         w_eff;
  logic [IDX_W-1:0]         lo_idx, hi_idx, age_tgt;
  logic                     accept, emit_load;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] sel_val, lo_val, hi_val;

  assign ws_ext = CMP_W'(ws_r);
  always_comb begin
    if (ws_ext == '0)
      w_eff = CNT_W'(1);
    else if (ws_ext > CMP_W'(MAX_WINDOW))
      w_eff = CNT_W'(MAX_WINDOW);
    else
      w_eff = CNT_W'(ws_ext);
  end

  assign lo_idx  = IDX_W'((w_eff - 1'b1) >> 1);
  assign hi_idx  = IDX_W'(w_eff >> 1);
  assign age_tgt = IDX_W'(fill_r - 1'b1);

  assign accept    = in_tvalid && in_tready;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = (fill_r >= w_eff) ? ST_EV_SEL : ST_INSERT;
      ST_EV_SEL:   state_nxt = ST_EV_SHIFT;
      ST_EV_SHIFT: state_nxt = ST_CHECK;
      ST_INSERT:   state_nxt = (fill_r + 1'b1 == w_eff) ? ST_PICK : ST_IDLE;
      ST_PICK:     state_nxt = ST_EMIT;
      ST_EMIT:     if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready     = 1'b0;
    ctl.op        = CELL_HOLD;
    ctl.sample    = sample_r;
    ctl.evict_val = ev_r;
    case (state_r)
      ST_IDLE:     in_tready = 1'b1;
      ST_EV_SHIFT: ctl.op = CELL_EVICT;
      ST_INSERT:   ctl.op = CELL_INSERT;
      default: begin
      end
    endcase
  end

  always_comb begin
    ws_nxt        = cfg_valid ? cfg_data : ws_r;
    sample_nxt    = accept ? signed'(in_tdata) : sample_r;
    ev_nxt        = (state_r == ST_EV_SEL) ? sel_val : ev_r;
    lo_nxt        = (state_r == ST_PICK) ? lo_val : lo_r;
    hi_nxt        = (state_r == ST_PICK) ? hi_val : hi_r;
    res_nxt       = emit_load ? ({lo_r[DATA_W-1], lo_r} + {hi_r[DATA_W-1], hi_r}) : res_r;
    out_valid_nxt = emit_load ? 1'b1 : (out_valid_r && !out_tready);
    fill_nxt      = fill_r;
    if (accept && in_tuser)
      fill_nxt = '0;
    else if (state_r == ST_EV_SHIFT)
      fill_nxt = fill_r - 1'b1;
    else if (state_r == ST_INSERT)
      fill_nxt = fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= WS_W'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    ev_r     <= ev_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    res_r    <= res_nxt;
  end

  swm_chain #(
    .MAX_WINDOW(MAX_WINDOW),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .fill   (fill_r),
    .age_tgt(age_tgt),
    .lo_idx (lo_idx),
    .hi_idx (hi_idx),
    .sel_val(sel_val),
    .lo_val (lo_val),
    .hi_val (hi_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40 - OUT_W){1'b0}}, res_r};

  `ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CNT_W'(MAX_WINDOW))
  `ASSERT_IMP(a_insert_room, state_r == ST_INSERT, fill_r < w_eff)
  `ASSERT_NEXT(a_insert_grow, state_r == ST_INSERT, fill_r == CNT_W'($past(fill_r) + 1'b1))
  `ASSERT_NEXT(a_evict_shrink, state_r == ST_EV_SHIFT, fill_r == CNT_W'($past(fill_r) - 1'b1))

endmodule
